>>> src/matrix_vector_multiply_macros.svh
// Assertion macros used by the matrix-vector multiply back end.
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define MVM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define MVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/mvm_pkg.sv
// Types and constants shared by the matrix-vector multiply modules.
package mvm_pkg;

	localparam int IDX_W     = 6;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 7;
	localparam int ROW_LIMIT = 64;
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		CMD_WR_MAT  = 2'd0,
		CMD_WR_VEC  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_WR_MAT,
		OP_WR_VEC,
		OP_COMPUTE
	} op_kind_t;

	typedef enum logic {
		CFG_ROW_COUNT = 1'b0,
		CFG_COL_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} op_t;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic signed [VAL_W-1:0] value;
		logic                    saturated;
		logic                    last;
	} res_t;

endpackage

>>> src/matrix_vector_multiply.sv
// Write items are applied while idle; a compute issues one multiply-accumulate per cycle
// unless the pipeline stalls, rows * max(col_count, 1) in all, a rate set by the single
// multiplier and read port. Results drain through a two-entry queue; a result facing a full
// queue stalls the whole MAC pipeline.
// arst_n clears control state and sets row_count = col_count = 1; stores are not cleared.
module matrix_vector_multiply #(
	parameter int MAX_DIM   = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       command,
	input  logic [mvm_pkg::IDX_W-1:0]        row,
	input  logic [mvm_pkg::IDX_W-1:0]        col,
	input  logic signed [mvm_pkg::VAL_W-1:0] value,
	output logic                             empty,
	input  logic                             pop,
	output logic [mvm_pkg::IDX_W-1:0]        out_row,
	output logic signed [mvm_pkg::VAL_W-1:0] out_value,
	output logic                             saturated,
	output logic                             last,
	input  logic                             cfg_write,
	input  logic                             cfg_index,
	input  logic [mvm_pkg::CNT_W-1:0]        cfg_data
);

	import mvm_pkg::*;

	logic                    op_empty;
	logic                    op_pop;
	op_t                     op;
	logic                    res_push;
	logic                    res_full;
	res_t                    res_item;
	res_t                    res_head;
	logic [$bits(res_t)-1:0] res_rdata;

	mvm_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.row      (row),
		.col      (col),
		.value    (value),
		.op_empty (op_empty),
		.op_pop   (op_pop),
		.op       (op)
	);

	mvm_back #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op_empty  (op_empty),
		.op_pop    (op_pop),
		.op        (op),
		.res_push  (res_push),
		.res_item  (res_item),
		.res_full  (res_full)
	);

	// Queue finished results for transfer out
	mvm_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_item),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_head  = res_t'(res_rdata);
	assign out_row   = res_head.row;
	assign out_value = res_head.value;
	assign saturated = res_head.saturated;
	assign last      = res_head.last;

endmodule

>>> src/mvm_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module mvm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/mvm_front.sv
// Front end: accepts input items, decodes them and queues the operations.
module mvm_front #(
	parameter int MAX_DIM = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     command,
	input  logic [mvm_pkg::IDX_W-1:0]      row,
	input  logic [mvm_pkg::IDX_W-1:0]      col,
	input  logic signed [mvm_pkg::VAL_W-1:0] value,
	output logic                           op_empty,
	input  logic                           op_pop,
	output mvm_pkg::op_t                   op
);

	import mvm_pkg::*;

	logic                q_full;
	logic                keep;
	op_t                 dec_op;
	logic [$bits(op_t)-1:0] q_rdata;

	// Classify the item; drop codes with no meaning and writes outside the stores
	always_comb begin
		keep         = 1'b0;
		dec_op.kind  = OP_COMPUTE;
		dec_op.row   = row;
		dec_op.col   = col;
		dec_op.value = value;
		case (command)
			CMD_WR_MAT: begin
				dec_op.kind = OP_WR_MAT;
				keep        = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
			end
			CMD_WR_VEC: begin
				dec_op.kind = OP_WR_VEC;
				keep        = (int'(col) < MAX_DIM);
			end
			CMD_COMPUTE: begin
				dec_op.kind = OP_COMPUTE;
				keep        = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full = q_full;

	mvm_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && keep),
		.wdata  (dec_op),
		.full   (q_full),
		.pop    (op_pop),
		.rdata  (q_rdata),
		.empty  (op_empty)
	);

	assign op = op_t'(q_rdata);

endmodule

>>> src/mvm_back.sv
// Back end: element stores, row/column sequencer and multiply-accumulate pipeline.
module mvm_back #(
	parameter int MAX_DIM   = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [mvm_pkg::CNT_W-1:0] cfg_data,
	input  logic                      op_empty,
	output logic                      op_pop,
	input  mvm_pkg::op_t              op,
	output logic                      res_push,
	output mvm_pkg::res_t             res_item,
	input  logic                      res_full
);

	import mvm_pkg::*;

	`include "matrix_vector_multiply_macros.svh"

	localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ACC_W   = 2 * VAL_W + DIM_W + 1;
	localparam int ROW_LIM = (MAX_DIM < ROW_LIMIT) ? MAX_DIM : ROW_LIMIT;
	localparam int TOP_BIT = VAL_W - 1 + FRAC_BITS;

	// Configuration registers
	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] col_count_q;
	logic [CNT_W-1:0] rows_eff;
	logic [CNT_W-1:0] cols_eff;

	// Sequencer
	seq_state_t       state_q;
	seq_state_t       state_d;
	logic             start;
	logic             issue;
	logic             mat_we;
	logic             vec_we;
	logic             adv;
	logic [IDX_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic [IDX_W-1:0] last_row_q;
	logic [CNT_W-1:0] last_col_q;
	logic             zero_q;
	logic             last_col;
	logic             last_row;

	// Stores
	logic [VAL_W-1:0] mat_mem [2**(2*DIM_W)];
	logic [VAL_W-1:0] vec_mem [2**DIM_W];
	logic [2*DIM_W-1:0] mat_waddr;
	logic [2*DIM_W-1:0] mat_raddr;

	// Pipeline
	logic                    valid_s1;
	logic                    first_s1;
	logic                    lastc_s1;
	logic                    lastr_s1;
	logic                    zero_s1;
	logic [IDX_W-1:0]        row_s1;
	logic signed [VAL_W-1:0] mat_s1;
	logic signed [VAL_W-1:0] vec_s1;

	logic                      valid_s2;
	logic                      first_s2;
	logic                      lastc_s2;
	logic                      lastr_s2;
	logic [IDX_W-1:0]          row_s2;
	logic signed [2*VAL_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_next;

	logic                    res_valid_s3;
	logic                    lastr_s3;
	logic [IDX_W-1:0]        row_s3;
	logic signed [ACC_W-1:0] sum_s3;
	logic                    fits;

	// Hold configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CNT_W'(1);
			col_count_q <= CNT_W'(1);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				CFG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Limit the counts to the store size
	assign rows_eff = (int'(row_count_q) > ROW_LIM) ? CNT_W'(ROW_LIM) : row_count_q;
	assign cols_eff = (int'(col_count_q) > MAX_DIM) ? CNT_W'(MAX_DIM) : col_count_q;

	// The whole pipeline stalls only while a finished result cannot enter the queue
	assign adv      = !(res_valid_s3 && res_full);
	assign last_col = (col_q == last_col_q);
	assign last_row = (row_q == last_row_q);

	// Next state: apply writes from idle, walk rows and columns for a compute
	always_comb begin
		state_d = state_q;
		op_pop  = 1'b0;
		mat_we  = 1'b0;
		vec_we  = 1'b0;
		start   = 1'b0;
		issue   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!op_empty) begin
					op_pop = 1'b1;
					case (op.kind)
						OP_WR_MAT: mat_we = 1'b1;
						OP_WR_VEC: vec_we = 1'b1;
						OP_COMPUTE: begin
							if (rows_eff != '0) begin
								start   = 1'b1;
								state_d = ST_RUN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				if (adv) begin
					issue = 1'b1;
					if (last_col && last_row) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the row and column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			last_row_q <= '0;
			last_col_q <= '0;
			zero_q     <= 1'b0;
		end else if (start) begin
			row_q      <= '0;
			col_q      <= '0;
			last_row_q <= IDX_W'(rows_eff - 1'b1);
			last_col_q <= (cols_eff == '0) ? '0 : cols_eff - 1'b1;
			zero_q     <= (cols_eff == '0);
		end else if (issue) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign mat_waddr = {DIM_W'(op.row), DIM_W'(op.col)};
	assign mat_raddr = {DIM_W'(row_q), DIM_W'(col_q)};

	// Write and read the stores
	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= op.value;
		end
		if (issue) begin
			mat_s1 <= mat_mem[mat_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[DIM_W'(op.col)] <= op.value;
		end
		if (issue) begin
			vec_s1 <= vec_mem[DIM_W'(col_q)];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			first_s1 <= (col_q == '0);
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
			zero_s1  <= zero_q;
			row_s1   <= row_q;
		end
	end

	// Stage 2: multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s1) begin
				prod_s2 <= '0;
			end else begin
				prod_s2 <= mat_s1 * vec_s1;
			end
			first_s2 <= first_s1;
			lastc_s2 <= lastc_s1;
			lastr_s2 <= lastr_s1;
			row_s2   <= row_s1;
		end
	end

	// Stage 3: accumulate exactly, capture the row sum on its last column
	assign acc_next = (first_s2 ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			acc_q <= acc_next;
		end
		if (adv) begin
			sum_s3   <= acc_next;
			row_s3   <= row_s2;
			lastr_s3 <= lastr_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s3 <= 1'b0;
		end else if (adv) begin
			res_valid_s3 <= valid_s2 && lastc_s2;
		end
	end

	// Floor-shift and saturate: the sum fits when the result's top bit and all bits above it agree
	assign fits = (&sum_s3[ACC_W-1:TOP_BIT]) || !(|sum_s3[ACC_W-1:TOP_BIT]);

	always_comb begin
		res_item.row       = row_s3;
		res_item.last      = lastr_s3;
		res_item.saturated = !fits;
		if (fits) begin
			res_item.value = sum_s3[TOP_BIT:FRAC_BITS];
		end else begin
			res_item.value = sum_s3[ACC_W-1] ? Q_MIN : Q_MAX;
		end
	end

	assign res_push = res_valid_s3 && adv;

	`MVM_ASSERT_NEXT(a_stall_hold, res_valid_s3 && res_full, res_valid_s3 && $stable(sum_s3), "stalled result changed")
	`MVM_ASSERT_IMPL(a_row_bound, state_q == ST_RUN, row_q <= last_row_q, "row counter past last row")
	`MVM_ASSERT_IMPL(a_col_bound, state_q == ST_RUN, col_q <= last_col_q, "column counter past last column")

endmodule
